### hw/rtl/ole_pkg.sv
// shared types, codes and defaults for the ordered list engine
// no dependencies; imported by every module of the block

package ole_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_W        = 32;
    localparam int POS_W        = 7;
    localparam int CNT_OUT_W    = 7;

    typedef logic [1:0]              t_op;
    typedef logic [1:0]              t_status;
    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic [POS_W-1:0]        t_pos;
    typedef logic [CNT_OUT_W-1:0]    t_cnt_out;

    localparam t_op OP_INSERT = 2'd0;
    localparam t_op OP_DELETE = 2'd1;
    localparam t_op OP_UPDATE = 2'd2;

    localparam t_status ST_DONE     = 2'd0;
    localparam t_status ST_BADPOS   = 2'd1;
    localparam t_status ST_NOTFOUND = 2'd2;
    localparam t_status ST_FULL     = 2'd3;

    // end-of-request report from the sequencer to the top level
    typedef struct packed {
        logic    fin;
        t_status status;
        logic    inc;
        logic    dec;
    } t_fin;

endpackage

### hw/rtl/ole_mem.sv
// entry store: one write port, one read port, registered read data
// depends on ole_pkg

module ole_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  ole_pkg::t_key i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output ole_pkg::t_key o_rdata
);
    import ole_pkg::*;

    t_key r_mem [DEPTH];
    t_key r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/ole_ctrl.sv
// request sequencer: search, shift and write-back over the entry store
// depends on ole_pkg

module ole_ctrl #(
    parameter int CAPACITY = 64,
    parameter int AW       = 6,
    parameter int CW       = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  ole_pkg::t_op      i_operation,
    input  ole_pkg::t_key     i_key,
    input  ole_pkg::t_pos     i_position,
    input  ole_pkg::t_key     i_new_value,
    input  logic [CW-1:0]     i_count,
    output ole_pkg::t_fin     o_fin,
    output logic              o_we,
    output logic [AW-1:0]     o_waddr,
    output ole_pkg::t_key     o_wdata,
    output logic              o_re,
    output logic [AW-1:0]     o_raddr,
    input  ole_pkg::t_key     i_rdata
);
    import ole_pkg::*;

    localparam int PCW = (CW > POS_W) ? CW : POS_W;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_INS_RD   = 3'd1;
    localparam logic [2:0] S_INS_WR   = 3'd2;
    localparam logic [2:0] S_SRCH_RD  = 3'd3;
    localparam logic [2:0] S_SRCH_CMP = 3'd4;
    localparam logic [2:0] S_DEL_RD   = 3'd5;
    localparam logic [2:0] S_DEL_WR   = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_pos, n_pos;
    t_op           r_op, n_op;
    t_key          r_key, n_key;
    t_key          r_new, n_new;

    logic [PCW-1:0] pos_w;
    logic [PCW-1:0] cnt_w;
    logic [CW-1:0]  idx_dn;
    logic [CW-1:0]  idx_up;

    assign pos_w  = PCW'(i_position);
    assign cnt_w  = PCW'(i_count);
    assign idx_dn = r_idx - 1'b1;
    assign idx_up = r_idx + 1'b1;
    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_pos   = r_pos;
        n_op    = r_op;
        n_key   = r_key;
        n_new   = r_new;
        o_fin   = '0;
        o_we    = 1'b0;
        o_waddr = r_idx[AW-1:0];
        o_wdata = i_rdata;
        o_re    = 1'b0;
        o_raddr = r_idx[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op  = i_operation;
                    n_key = i_key;
                    n_new = i_new_value;
                    n_pos = pos_w[CW-1:0];
                    unique case (i_operation) inside
                        OP_INSERT: begin
                            if (pos_w > cnt_w) begin
                                o_fin.fin    = 1'b1;
                                o_fin.status = ST_BADPOS;
                            end else if (i_count == CW'(CAPACITY)) begin
                                o_fin.fin    = 1'b1;
                                o_fin.status = ST_FULL;
                            end else begin
                                n_idx   = i_count;
                                n_state = S_INS_RD;
                            end
                        end
                        OP_DELETE, OP_UPDATE: begin
                            if (i_count == '0) begin
                                o_fin.fin    = 1'b1;
                                o_fin.status = ST_NOTFOUND;
                            end else begin
                                n_idx   = '0;
                                n_state = S_SRCH_RD;
                            end
                        end
                        default: begin
                            o_fin.fin    = 1'b1;
                            o_fin.status = ST_BADPOS;
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                if (r_idx == r_pos) begin
                    // gap has reached the target slot
                    o_we         = 1'b1;
                    o_wdata      = r_key;
                    o_fin.fin    = 1'b1;
                    o_fin.status = ST_DONE;
                    o_fin.inc    = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_re    = 1'b1;
                    o_raddr = idx_dn[AW-1:0];
                    n_state = S_INS_WR;
                end
            end
            S_INS_WR: begin
                o_we    = 1'b1;
                n_idx   = idx_dn;
                n_state = S_INS_RD;
            end
            S_SRCH_RD: begin
                o_re    = 1'b1;
                n_state = S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                if (i_rdata == r_key) begin
                    if (r_op == OP_UPDATE) begin
                        o_we         = 1'b1;
                        o_wdata      = r_new;
                        o_fin.fin    = 1'b1;
                        o_fin.status = ST_DONE;
                        n_state      = S_IDLE;
                    end else begin
                        n_state = S_DEL_RD;
                    end
                end else if (idx_up == i_count) begin
                    o_fin.fin    = 1'b1;
                    o_fin.status = ST_NOTFOUND;
                    n_state      = S_IDLE;
                end else begin
                    n_idx   = idx_up;
                    n_state = S_SRCH_RD;
                end
            end
            S_DEL_RD: begin
                if (idx_up == i_count) begin
                    o_fin.fin    = 1'b1;
                    o_fin.status = ST_DONE;
                    o_fin.dec    = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_re    = 1'b1;
                    o_raddr = idx_up[AW-1:0];
                    n_state = S_DEL_WR;
                end
            end
            S_DEL_WR: begin
                o_we    = 1'b1;
                n_idx   = idx_up;
                n_state = S_DEL_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_pos <= n_pos;
        r_op  <= n_op;
        r_key <= n_key;
        r_new <= n_new;
    end

endmodule

### hw/rtl/ordered_list_engine.sv
// ordered list engine: a rejected request ends without touching the entry store; an insert
// shifts the entries from its position up by one, an update searches and rewrites the match,
// a delete searches and shifts the later entries down, and a failed search reads every entry
// one request at a time, paced by the read then write-back walk over the entry store;
// result shown for one cycle on o_done and the receiver cannot stall it
// synchronous active-low reset empties the list; entry contents are left as they were
// depends on ole_pkg, ole_mem, ole_ctrl

module ordered_list_engine #(
    parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ole_pkg::t_op      i_operation,
    input  ole_pkg::t_key     i_key,
    input  ole_pkg::t_pos     i_position,
    input  ole_pkg::t_key     i_new_value,
    output logic              o_done,
    output ole_pkg::t_status  o_status,
    output ole_pkg::t_cnt_out o_entry_count
);
    import ole_pkg::*;

    // address bits for the store, count bits that can hold CAPACITY itself
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;

    // number of entries held; entries live at positions 0 .. count-1
    logic [CW-1:0] r_count;
    logic          r_done;
    t_status       r_status;

    t_fin          fin;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_key          mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    t_key          mem_rdata;
    logic [EW-1:0] count_ext;

    // sequencer walks the store one read/write pair per shift step
    ole_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_operation (i_operation),
        .i_key       (i_key),
        .i_position  (i_position),
        .i_new_value (i_new_value),
        .i_count     (r_count),
        .o_fin       (fin),
        .o_we        (mem_we),
        .o_waddr     (mem_waddr),
        .o_wdata     (mem_wdata),
        .o_re        (mem_re),
        .o_raddr     (mem_raddr),
        .i_rdata     (mem_rdata)
    );

    // entry store
    ole_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // count moves on the same edge that captures the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= fin.fin;
            if (fin.inc) begin
                r_count <= r_count + 1'b1;
            end else if (fin.dec) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // status is payload, qualified by the strobe
    always_ff @(posedge i_clk) begin
        if (fin.fin) begin
            r_status <= fin.status;
        end
    end

    // report the low bits of the count
    assign count_ext     = EW'(r_count);
    assign o_entry_count = count_ext[CNT_OUT_W-1:0];
    assign o_done        = r_done;
    assign o_status      = r_status;

endmodule

### hw/rtl/ole_checker.sv
// port-level checks for the ordered list engine, bound onto the top level
// depends on ole_pkg and ordered_list_engine

module ole_checker #(
    parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input ole_pkg::t_op      i_operation,
    input logic              o_done,
    input ole_pkg::t_status  o_status,
    input ole_pkg::t_cnt_out o_entry_count
);
    import ole_pkg::*;

    localparam t_cnt_out CAP_LOW = CNT_OUT_W'(CAPACITY);

    // result cycle always leaves the engine free for the next request
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // an accepted request either completes at once or holds busy
    a_accept_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy ^ o_done))
        else $error("accepted request neither busy nor done");

    // unused operation code is rejected straight away as bad position
    a_unused_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation != OP_INSERT && i_operation != OP_DELETE
         && i_operation != OP_UPDATE) |=> (o_done && o_status == ST_BADPOS))
        else $error("unused operation not rejected");

    // count moves only with a successful result
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (!o_done || o_status != ST_DONE))
        |-> $stable(o_entry_count))
        else $error("entry count changed without a completed request");

    // full is only reported at capacity
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_FULL) |-> (o_entry_count == CAP_LOW))
        else $error("full reported below capacity");

endmodule

bind ordered_list_engine ole_checker #(
    .CAPACITY (CAPACITY)
) u_ole_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_operation   (i_operation),
    .o_done        (o_done),
    .o_status      (o_status),
    .o_entry_count (o_entry_count)
);
